// ===== hw/rtl/cdep_pkg.sv =====
package cdep_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LENGTH = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  HEADER_LENGTH_RST  = 8'd16;
  localparam logic [15:0] PAYLOAD_LENGTH_RST = 16'd0;

  // Record kinds
  localparam logic [1:0] KIND_LOC    = 2'd0;
  localparam logic [1:0] KIND_SIG    = 2'd1;
  localparam logic [1:0] KIND_VENDOR = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Group queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_LOC_LO  = 7'b0000010,
    PH_LOC_HI  = 7'b0000100,
    PH_SIG_CNT = 7'b0001000,
    PH_VEN_CNT = 7'b0010000,
    PH_SIG     = 7'b0100000,
    PH_VEN     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [13:0] element_number;
  } record_t;

  // All records caused by one word: an optional parse record and an optional end record
  typedef struct packed {
    logic        has_main;
    record_t     main;
    logic        has_end;
    logic [13:0] end_count;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/cdep_ifs.sv =====
interface cdep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface cdep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] record_value;
  logic [13:0] element_number;
  logic        last_record;

  modport source (output valid, output record_kind, output record_value,
                  output element_number, output last_record, input ready);
  modport sink (input valid, input record_kind, input record_value,
                input element_number, input last_record, output ready);
endinterface

// ===== hw/rtl/cdep_front.sv =====
module cdep_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  cdep_in_if.sink                              in_byte,
  input  logic                                 cfg_we,
  input  logic [cdep_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cdep_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  cdep_pkg::q_status_t                  q_status,
  output logic                                 push,
  output cdep_pkg::group_t                     push_data
);

  logic [7:0]        hdr_len_r;
  logic [15:0]       pay_len_r;

  logic [15:0]       pos_r, pos_nxt, pos_e;
  cdep_pkg::phase_t  phase_r, phase_nxt, phase_e, ph;
  logic [7:0]        sig_r, sig_nxt, sig_e;
  logic [7:0]        ven_r, ven_nxt, ven_e;
  logic [31:0]       field_r, field_nxt, field_e;
  logic [1:0]        bif_r, bif_nxt, bif_e, bif_inc;
  logic [13:0]       count_r, count_nxt, count_e, cur_elem;
  logic              stop_r, stop_nxt, stop_e;
  logic [16:0]       elem_end;
  logic [7:0]        b;
  logic              accept;

  function automatic cdep_pkg::phase_t pick_phase(input logic [7:0] sig, input logic [7:0] ven);
    cdep_pkg::phase_t r;
    if (sig != 8'd0) r = cdep_pkg::PH_SIG;
    else if (ven != 8'd0) r = cdep_pkg::PH_VEN;
    else r = cdep_pkg::PH_LOC_LO;
    return r;
  endfunction

  assign in_byte.ready = !q_status.full;
  assign accept = in_byte.valid && in_byte.ready;
  assign b = in_byte.data_byte;

  // A first word starts from a cleared parse state
  always_comb begin
    if (in_byte.first_byte) begin
      pos_e   = 16'd0;
      phase_e = cdep_pkg::PH_HEADER;
      sig_e   = 8'd0;
      ven_e   = 8'd0;
      field_e = 32'd0;
      bif_e   = 2'd0;
      count_e = 14'd0;
      stop_e  = 1'b0;
    end else begin
      pos_e   = pos_r;
      phase_e = phase_r;
      sig_e   = sig_r;
      ven_e   = ven_r;
      field_e = field_r;
      bif_e   = bif_r;
      count_e = count_r;
      stop_e  = stop_r;
    end
  end

  // Parse one word
  always_comb begin
    phase_nxt = phase_e;
    sig_nxt   = sig_e;
    ven_nxt   = ven_e;
    field_nxt = field_e;
    bif_nxt   = bif_e;
    count_nxt = count_e;
    stop_nxt  = stop_e;
    push_data = '0;
    cur_elem  = count_e - 14'd1;
    bif_inc   = bif_e + 2'd1;
    elem_end  = {1'b0, pos_e} + 17'd1 + {8'd0, sig_e, 1'b0} + {7'd0, b, 2'b00};
    ph        = phase_e;

    if (pos_e < pay_len_r && !stop_e) begin
      if (phase_e == cdep_pkg::PH_HEADER && pos_e >= {8'd0, hdr_len_r}) begin
        ph = cdep_pkg::PH_LOC_LO;
      end
      case (ph)
        cdep_pkg::PH_HEADER: begin
        end
        cdep_pkg::PH_LOC_LO: begin
          field_nxt = {24'd0, b};
          phase_nxt = cdep_pkg::PH_LOC_HI;
        end
        cdep_pkg::PH_LOC_HI: begin
          field_nxt = {16'd0, b, field_e[7:0]};
          phase_nxt = cdep_pkg::PH_SIG_CNT;
        end
        cdep_pkg::PH_SIG_CNT: begin
          sig_nxt   = b;
          phase_nxt = cdep_pkg::PH_VEN_CNT;
        end
        cdep_pkg::PH_VEN_CNT: begin
          ven_nxt = b;
          // Drop the element and all that follows when it overruns the payload
          if (elem_end > {1'b0, pay_len_r}) begin
            stop_nxt = 1'b1;
          end else begin
            push_data.has_main            = 1'b1;
            push_data.main.kind           = cdep_pkg::KIND_LOC;
            push_data.main.value          = {16'd0, field_e[15:0]};
            push_data.main.element_number = count_e;
            count_nxt = count_e + 14'd1;
            field_nxt = 32'd0;
            bif_nxt   = 2'd0;
            phase_nxt = pick_phase(sig_e, b);
          end
        end
        cdep_pkg::PH_SIG: begin
          field_nxt = field_e | (bif_e[0] ? {16'd0, b, 8'd0} : {24'd0, b});
          bif_nxt   = bif_inc;
          if (bif_inc == 2'd2) begin
            push_data.has_main            = 1'b1;
            push_data.main.kind           = cdep_pkg::KIND_SIG;
            push_data.main.value          = {16'd0, field_nxt[15:0]};
            push_data.main.element_number = cur_elem;
            sig_nxt   = sig_e - 8'd1;
            field_nxt = 32'd0;
            bif_nxt   = 2'd0;
            phase_nxt = pick_phase(sig_e - 8'd1, ven_e);
          end
        end
        cdep_pkg::PH_VEN: begin
          // Vendor id lands in the upper half, model id in the lower
          case (bif_e)
            2'd0:    field_nxt = field_e | {8'd0, b, 16'd0};
            2'd1:    field_nxt = field_e | {b, 24'd0};
            2'd2:    field_nxt = field_e | {24'd0, b};
            default: field_nxt = field_e | {16'd0, b, 8'd0};
          endcase
          if (bif_e == 2'd3) begin
            push_data.has_main            = 1'b1;
            push_data.main.kind           = cdep_pkg::KIND_VENDOR;
            push_data.main.value          = field_nxt;
            push_data.main.element_number = cur_elem;
            ven_nxt   = ven_e - 8'd1;
            field_nxt = 32'd0;
            bif_nxt   = 2'd0;
            phase_nxt = pick_phase(sig_e, ven_e - 8'd1);
          end else begin
            bif_nxt = bif_inc;
          end
        end
        default: begin
        end
      endcase
    end

    // End record at the last payload word
    if (pay_len_r != 16'd0 && pos_e == pay_len_r - 16'd1) begin
      push_data.has_end   = 1'b1;
      push_data.end_count = count_nxt;
    end

    pos_nxt = (pos_e != 16'hFFFF) ? pos_e + 16'd1 : pos_e;
  end

  assign push = accept && (push_data.has_main || push_data.has_end);

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_len_r <= cdep_pkg::HEADER_LENGTH_RST;
      pay_len_r <= cdep_pkg::PAYLOAD_LENGTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == cdep_pkg::REG_HEADER_LENGTH) hdr_len_r <= cfg_wdata[7:0];
      if (cfg_index == cdep_pkg::REG_PAYLOAD_LENGTH) pay_len_r <= cfg_wdata[15:0];
    end
  end

  // Advance parse state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 16'd0;
      phase_r <= cdep_pkg::PH_HEADER;
      sig_r   <= 8'd0;
      ven_r   <= 8'd0;
      field_r <= 32'd0;
      bif_r   <= 2'd0;
      count_r <= 14'd0;
      stop_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      sig_r   <= sig_nxt;
      ven_r   <= ven_nxt;
      field_r <= field_nxt;
      bif_r   <= bif_nxt;
      count_r <= count_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// ===== hw/rtl/cdep_queue.sv =====
module cdep_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cdep_pkg::group_t     push_data,
  input  logic                 pop,
  output cdep_pkg::group_t     pop_data,
  output cdep_pkg::q_status_t  q_status
);

  cdep_pkg::group_t                        slots [cdep_pkg::QUEUE_DEPTH];
  logic [cdep_pkg::QUEUE_PTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [cdep_pkg::QUEUE_CNT_W-1:0]        cnt_r, cnt_nxt;

  assign q_status.full  = (cnt_r == cdep_pkg::QUEUE_CNT_W'(cdep_pkg::QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign pop_data       = slots[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Store groups
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("group pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_status.empty))
    else $error("group popped from empty queue");
`endif

endmodule

// ===== hw/rtl/cdep_back.sv =====
module cdep_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdep_pkg::q_status_t  q_status,
  input  cdep_pkg::group_t     pop_data,
  output logic                 pop,
  cdep_out_if.source           out_rec
);

  logic                    out_valid_r, out_valid_nxt;
  cdep_pkg::record_t       rec_r, rec_nxt;
  logic                    last_r, last_nxt;
  logic                    pend_r, pend_nxt;
  logic [13:0]             pend_cnt_r, pend_cnt_nxt;
  logic                    out_free;

  assign out_free = !out_valid_r || out_rec.ready;
  assign pop      = out_free && !pend_r && !q_status.empty;

  // Load the next record into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    rec_nxt       = rec_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (out_free) begin
      if (pend_r) begin
        out_valid_nxt          = 1'b1;
        rec_nxt.kind           = cdep_pkg::KIND_END;
        rec_nxt.value          = {18'd0, pend_cnt_r};
        rec_nxt.element_number = 14'd0;
        last_nxt               = 1'b1;
        pend_nxt               = 1'b0;
      end else if (!q_status.empty) begin
        out_valid_nxt = 1'b1;
        if (pop_data.has_main) begin
          rec_nxt      = pop_data.main;
          last_nxt     = !pop_data.has_end;
          pend_nxt     = pop_data.has_end;
          pend_cnt_nxt = pop_data.end_count;
        end else begin
          rec_nxt.kind           = cdep_pkg::KIND_END;
          rec_nxt.value          = {18'd0, pop_data.end_count};
          rec_nxt.element_number = 14'd0;
          last_nxt               = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    last_r     <= last_nxt;
    pend_cnt_r <= pend_cnt_nxt;
  end

  assign out_rec.valid          = out_valid_r;
  assign out_rec.record_kind    = rec_r.kind;
  assign out_rec.record_value   = rec_r.value;
  assign out_rec.element_number = rec_r.element_number;
  assign out_rec.last_record    = last_r;

`ifndef SYNTHESIS
  a_pend_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && !last_r && rec_r.kind != cdep_pkg::KIND_END))
    else $error("pending end record without its parse record in flight");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rec_r.kind == cdep_pkg::KIND_END) |-> last_r)
    else $error("end record not flagged last");
  a_not_last_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> pend_r)
    else $error("record not last but nothing follows");
`endif

endmodule

// ===== hw/rtl/composition_data_element_parser_top.sv =====
// Records of an accepted word are written into the group queue and then loaded into the
// output register, from which the first of them is presented.
// Throughput: one word per cycle while the queue is not full; records leave at one per
// cycle while the output is ready, a word's parse record before its end record.
// A four-group queue between parser and output stage absorbs output stalls.
// Reset (rst_n low, synchronous): parse state cleared, header_length 16,
// payload_length 0, queue and output register empty.
module composition_data_element_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  cdep_in_if.sink                           in_byte,
  cdep_out_if.source                        out_rec,
  input  logic                              cfg_we,
  input  logic [cdep_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cdep_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  cdep_pkg::q_status_t q_status;
  cdep_pkg::group_t    push_data;
  cdep_pkg::group_t    pop_data;
  logic                push;
  logic                pop;

  cdep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  cdep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  cdep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_data (pop_data),
    .pop      (pop),
    .out_rec  (out_rec)
  );

endmodule

// ===== tb/composition_data_element_parser_top_tb.sv =====
`timescale 1ns / 1ps
module composition_data_element_parser_top_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned RANDOM_BYTES = 350;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [13:0] element_number;
    logic        last_record;
  } parsed_record_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [cdep_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cdep_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cdep_in_if in_byte_if();
  cdep_out_if out_rec_if();

  composition_data_element_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte_if),
    .out_rec   (out_rec_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Parser mirror: registers and parse state
  logic [7:0]        hdr_len_m;
  logic [15:0]       pay_len_m;
  logic [15:0]       byte_pos;
  logic [16:0]       elem_end;
  cdep_pkg::phase_t  phase;
  logic [7:0]        sig_left;
  logic [7:0]        ven_left;
  logic [31:0]       assembly;
  logic [1:0]        field_byte;
  logic [13:0]       elem_count;
  logic              stopped;

  parsed_record_t pending_records[$];
  logic [7:0] message[$];
  int unsigned failures = 0;
  int unsigned bytes_sent = 0;
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  bit long_hold_req = 1'b0;

  function automatic int unsigned at_most(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic void clear_parse_model();
    byte_pos = '0;
    elem_end = '0;
    phase = cdep_pkg::PH_HEADER;
    sig_left = '0;
    ven_left = '0;
    assembly = '0;
    field_byte = '0;
    elem_count = '0;
    stopped = 1'b0;
  endfunction

  function automatic void next_model_phase();
    assembly = '0;
    field_byte = '0;
    if (sig_left != 0) phase = cdep_pkg::PH_SIG;
    else if (ven_left != 0) phase = cdep_pkg::PH_VEN;
    else phase = cdep_pkg::PH_LOC_LO;
  endfunction

  function automatic parsed_record_t make_record(input logic [1:0] kind,
                                                 input logic [31:0] value,
                                                 input logic [13:0] elem);
    parsed_record_t rec;
    rec.kind = kind;
    rec.value = value;
    rec.element_number = elem;
    rec.last_record = 1'b0;
    return rec;
  endfunction

  // Advance the mirror by one accepted word and queue the records it causes
  function automatic void parse_byte_model(input logic [7:0] b, input logic first);
    parsed_record_t caused[2];
    int n;
    logic [13:0] cur_elem;
    cdep_pkg::phase_t ph;
    n = 0;
    if (first) clear_parse_model();
    cur_elem = elem_count - 14'd1;
    if (byte_pos < pay_len_m && !stopped) begin
      ph = phase;
      if (ph == cdep_pkg::PH_HEADER && byte_pos >= 16'(hdr_len_m)) ph = cdep_pkg::PH_LOC_LO;
      case (ph)
        cdep_pkg::PH_LOC_LO: begin
          assembly = {24'd0, b};
          phase = cdep_pkg::PH_LOC_HI;
        end
        cdep_pkg::PH_LOC_HI: begin
          assembly = {16'd0, b, assembly[7:0]};
          phase = cdep_pkg::PH_SIG_CNT;
        end
        cdep_pkg::PH_SIG_CNT: begin
          sig_left = b;
          phase = cdep_pkg::PH_VEN_CNT;
        end
        cdep_pkg::PH_VEN_CNT: begin
          ven_left = b;
          elem_end = 17'(byte_pos + 1 + 2 * sig_left + 4 * ven_left);
          if (elem_end > 17'(pay_len_m)) begin
            stopped = 1'b1;
          end else begin
            caused[n] = make_record(cdep_pkg::KIND_LOC, {16'd0, assembly[15:0]},
                                    elem_count);
            n++;
            elem_count = elem_count + 14'd1;
            next_model_phase();
          end
        end
        cdep_pkg::PH_SIG: begin
          assembly = assembly | (32'(b) << (8 * field_byte[0]));
          field_byte = field_byte + 2'd1;
          if (field_byte == 2'd2) begin
            caused[n] = make_record(cdep_pkg::KIND_SIG, {16'd0, assembly[15:0]}, cur_elem);
            n++;
            sig_left = sig_left - 8'd1;
            next_model_phase();
          end
        end
        cdep_pkg::PH_VEN: begin
          // vendor id lands in the upper half, model id in the lower half
          assembly = assembly | (32'(b) << (8 * (field_byte ^ 2'd2)));
          if (field_byte == 2'd3) begin
            caused[n] = make_record(cdep_pkg::KIND_VENDOR, assembly, cur_elem);
            n++;
            ven_left = ven_left - 8'd1;
            next_model_phase();
          end else begin
            field_byte = field_byte + 2'd1;
          end
        end
        default: ;
      endcase
    end
    if (pay_len_m != 0 && byte_pos == pay_len_m - 16'd1) begin
      caused[n] = make_record(cdep_pkg::KIND_END, 32'(elem_count), 14'd0);
      n++;
    end
    if (n > 0) caused[n-1].last_record = 1'b1;
    for (int i = 0; i < n; i++) pending_records.push_back(caused[i]);
    if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = pick_gap(tx_gaps_on);
    if (gap != 0) begin
      @(negedge clk);
      in_byte_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_byte_if.valid <= 1'b1;
    in_byte_if.data_byte <= b;
    in_byte_if.first_byte <= first;
    do @(posedge clk); while (!in_byte_if.ready);
    parse_byte_model(b, first);
    bytes_sent++;
  endtask

  task automatic send_message(input bit with_first, input int unsigned count);
    for (int i = 0; i < count && i < message.size(); i++)
      send_byte(message[i], with_first && i == 0);
  endtask

  task automatic write_reg(input logic [cdep_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cdep_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cdep_pkg::REG_HEADER_LENGTH) hdr_len_m = value[7:0];
    else pay_len_m = value;
  endtask

  task automatic configure(input int unsigned hl, input int unsigned pl);
    write_reg(cdep_pkg::REG_HEADER_LENGTH, cdep_pkg::CFG_DATA_W'(hl));
    write_reg(cdep_pkg::REG_PAYLOAD_LENGTH, cdep_pkg::CFG_DATA_W'(pl));
  endtask

  // Drop valid, wait for every pending record, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_byte_if.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Header, then element descriptors that mostly fit, cut at the payload end, plus tail words
  task automatic build_message(input int unsigned hl, input int unsigned pl,
                               input int unsigned fit_pct, input int unsigned max_models,
                               input int unsigned tail);
    int unsigned room;
    int unsigned ns;
    int unsigned nv;
    message.delete();
    while (message.size() < pl && message.size() < hl) message.push_back(8'($urandom));
    while (message.size() < pl) begin
      room = pl - message.size();
      if (room >= 4 && $urandom_range(0, 99) < fit_pct) begin
        room = room - 4;
        nv = $urandom_range(0, at_most(room / 4, max_models));
        ns = $urandom_range(0, at_most((room - 4 * nv) / 2, max_models));
      end else if ($urandom_range(0, 1) == 0) begin
        ns = $urandom_range(0, 255);
        nv = $urandom_range(0, 255);
      end else begin
        ns = $urandom_range(0, max_models);
        nv = $urandom_range(0, max_models);
      end
      message.push_back(8'($urandom));
      message.push_back(8'($urandom));
      message.push_back(8'(ns));
      message.push_back(8'(nv));
      for (int i = 0; i < 2 * ns + 4 * nv && message.size() < pl; i++)
        message.push_back(8'($urandom));
    end
    while (message.size() > pl) void'(message.pop_back());
    repeat (tail) message.push_back(8'($urandom));
    if (message.size() == 0) message.push_back(8'($urandom));
  endtask

  // Reset values: header 16, payload 0, then words that carry on without a first mark
  task automatic test_reset_defaults();
    repeat (20) send_byte(8'($urandom), 1'b0);
    settle();
    write_reg(cdep_pkg::REG_PAYLOAD_LENGTH, cdep_pkg::CFG_DATA_W'(30));
    message = '{8'h21, 8'h43, 8'h01, 8'h00, 8'h99, 8'h88, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h3C, 8'hC3};
    send_message(1'b0, message.size());
    settle();
  endtask

  // Every record kind, field extremes, a partial descriptor and words past the payload
  task automatic test_directed_records();
    configure(0, 24);
    message = '{8'h34, 8'h12, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A,
                8'h77, 8'h01, 8'h55, 8'hAA};
    send_message(1'b1, message.size());
    settle();
  endtask

  // Location and end record from the same word; a one-word payload
  task automatic test_two_records_per_byte();
    configure(0, 4);
    message = '{8'hAB, 8'hCD, 8'h00, 8'h00, 8'hF0};
    send_message(1'b1, message.size());
    settle();
    write_reg(cdep_pkg::REG_PAYLOAD_LENGTH, cdep_pkg::CFG_DATA_W'(1));
    message = '{8'h5A, 8'h0F};
    send_message(1'b1, message.size());
    settle();
  endtask

  // Element too long for the payload stops parsing; end record still comes
  task automatic test_element_overflow();
    configure(2, 10);
    message = '{8'h11, 8'h22, 8'h01, 8'h02, 8'hFF, 8'hFF, 8'h33, 8'h44, 8'h55, 8'h66};
    send_message(1'b1, message.size());
    settle();
  endtask

  // Hold the output off long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    configure(0, 200);
    message.delete();
    message.push_back(8'h10);
    message.push_back(8'h20);
    message.push_back(8'd50);
    message.push_back(8'd10);
    repeat (140) message.push_back(8'($urandom));
    repeat (14) begin
      message.push_back(8'($urandom));
      message.push_back(8'($urandom));
      message.push_back(8'h00);
      message.push_back(8'h00);
    end
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    long_hold_req = 1'b1;
    send_message(1'b1, message.size());
    settle();
  endtask

  task automatic test_config_extremes();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    configure(255, 0);
    build_message(0, 40, 90, 3, 0);
    send_message(1'b1, message.size());
    settle();
    configure(255, 300);
    build_message(255, 300, 90, 3, 3);
    send_message(1'b1, message.size());
    settle();
    // largest payload, message broken off long before its end
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    configure(255, 65535);
    build_message(255, 300, 97, 4, 0);
    send_message(1'b1, message.size());
    settle();
    configure(0, 65535);
    build_message(0, 120, 90, 3, 0);
    send_message(1'b1, message.size());
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned hl;
    int unsigned pl;
    int unsigned r;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 10) hl = 0;
      else if (r < 15) hl = 255;
      else hl = $urandom_range(1, 20);
      r = $urandom_range(0, 99);
      if (r < 5) pl = 0;
      else if (r < 10) pl = $urandom_range(1, hl + 4);
      else pl = hl + $urandom_range(4, 100);
      configure(hl, pl);
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        build_message(hl, pl, 90, 4, $urandom_range(0, 2));
        if (r < 70) begin
          send_message(1'b1, message.size());
        end else if (r < 80) begin
          // broken off part way, a following message with a first word restarts the parser
          send_message(1'b1, $urandom_range(1, message.size()));
        end else if (r < 90) begin
          repeat ($urandom_range(1, 20))
            send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        end else begin
          send_message(1'b0, message.size());
        end
      end
      settle();
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin : record_sink
    int unsigned stall;
    out_rec_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_rec_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        out_rec_if.ready <= 1'b1;
      end else begin
        stall = pick_gap(rx_stalls_on);
        if (stall != 0) begin
          out_rec_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_rec_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted record with the oldest pending one
  always @(posedge clk) begin : check_records
    parsed_record_t want;
    if (rst_n === 1'b1 && out_rec_if.valid === 1'b1 && out_rec_if.ready === 1'b1) begin
      if (pending_records.size() == 0) begin
        $error("record with nothing pending: kind %0d value %0h",
               out_rec_if.record_kind, out_rec_if.record_value);
        failures++;
      end else begin
        want = pending_records.pop_front();
        if (out_rec_if.record_kind !== want.kind) begin
          $error("record_kind: expected %0d, got %0d", want.kind, out_rec_if.record_kind);
          failures++;
        end
        if (out_rec_if.record_value !== want.value) begin
          $error("record_value: expected %0h, got %0h", want.value, out_rec_if.record_value);
          failures++;
        end
        if (out_rec_if.element_number !== want.element_number) begin
          $error("element_number: expected %0d, got %0d", want.element_number,
                 out_rec_if.element_number);
          failures++;
        end
        if (out_rec_if.last_record !== want.last_record) begin
          $error("last_record: expected %0d, got %0d", want.last_record,
                 out_rec_if.last_record);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("composition_data_element_parser_top_tb: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_byte_if.valid = 1'b0;
    in_byte_if.data_byte = '0;
    in_byte_if.first_byte = 1'b0;
    hdr_len_m = cdep_pkg::HEADER_LENGTH_RST;
    pay_len_m = cdep_pkg::PAYLOAD_LENGTH_RST;
    clear_parse_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_records();
    test_two_records_per_byte();
    test_element_overflow();
    test_backpressure();
    test_config_extremes();
    test_random_traffic();

    if (failures == 0) begin
      $display("composition_data_element_parser_top_tb: clean");
    end else begin
      $display("composition_data_element_parser_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cdep_pkg.sv
hw/rtl/cdep_ifs.sv
hw/rtl/cdep_front.sv
hw/rtl/cdep_queue.sv
hw/rtl/cdep_back.sv
hw/rtl/composition_data_element_parser_top.sv
tb/composition_data_element_parser_top_tb.sv
